// ===== src/chbd_pkg.sv =====
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

	// Framing characters
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Decoder phases
	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_SIZE_LF = 3'd1,
		PH_DATA    = 3'd2,
		PH_DATA_CR = 3'd3,
		PH_DATA_LF = 3'd4,
		PH_DONE    = 3'd5,
		PH_ERROR   = 3'd6
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_DONE    = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	// Error codes
	typedef enum logic [2:0] {
		ERR_NO_DIGIT    = 3'd0,
		ERR_MANY_DIGITS = 3'd1,
		ERR_SIZE_CRLF   = 3'd2,
		ERR_SIZE_LARGE  = 3'd3,
		ERR_DATA_CRLF   = 3'd4
	} err_t;

	// Classified byte, as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} item_t;

	// Queue to back-end handshake
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

endpackage

// ===== src/http_chunked_body_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Strips HTTP/1.1 chunked framing from a body byte stream, passes payload
// bytes on, and reports completion with total length or a held error.
// ----------------------------------------------------------------------------
//  channel  handshake             fields
//  in       in_valid / in_ready   body_byte[7:0], first
//  out      out_valid / out_ready kind[1:0], payload[7:0], error_code[2:0],
//                                 body_length[31:0]
//
//  One beat per cycle sustained while out_ready is high; one result beat per
//  input beat. A beat is classified and queued, then the framing state
//  machine consumes it into the result register.
//  The two-entry queue decouples input from output; in_ready drops only
//  when it is full. arst_n returns the decoder to the size-digit phase.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
	parameter int MAX_SIZE_DIGITS = 8,
	parameter int TOTAL_BITS      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  body_byte,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload,
	output logic [2:0]  error_code,
	output logic [31:0] body_length
);

	chbd_pkg::item_t  cls_item;
	chbd_pkg::q_out_t q_head;
	logic             q_full;
	logic             q_pop;

	assign in_ready = !q_full;

	// Front end: byte classification
	chbd_front u_front (
		.body_byte (body_byte),
		.first     (first),
		.item      (cls_item)
	);

	// Decoupling queue
	chbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && in_ready),
		.push_item (cls_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	// Back end: framing state machine
	chbd_back #(
		.MAX_SIZE_DIGITS (MAX_SIZE_DIGITS),
		.TOTAL_BITS      (TOTAL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.payload     (payload),
		.error_code  (error_code),
		.body_length (body_length)
	);

endmodule

// ===== src/chbd_front.sv =====
// ----------------------------------------------------------------------------
// chbd_front
// Classifies each incoming beat (hex digit, CR, LF) for the back end.
// ----------------------------------------------------------------------------
module chbd_front (
	input  logic [7:0]          body_byte,
	input  logic                first,
	output chbd_pkg::item_t     item
);

	logic       is_dec;
	logic       is_lo;
	logic       is_up;
	logic [7:0] dec_off;
	logic [7:0] lo_off;
	logic [7:0] up_off;

	// Character class decode
	always_comb begin
		is_dec  = (body_byte >= 8'h30) && (body_byte <= 8'h39);
		is_lo   = (body_byte >= 8'h61) && (body_byte <= 8'h66);
		is_up   = (body_byte >= 8'h41) && (body_byte <= 8'h46);
		dec_off = body_byte - 8'h30;
		lo_off  = body_byte - 8'h57; // 'a' - 10
		up_off  = body_byte - 8'h37; // 'A' - 10

		item.data    = body_byte;
		item.first   = first;
		item.is_hex  = is_dec | is_lo | is_up;
		item.is_cr   = (body_byte == chbd_pkg::CHAR_CR);
		item.is_lf   = (body_byte == chbd_pkg::CHAR_LF);
		priority if (is_dec) begin
			item.hex_val = dec_off[3:0];
		end else if (is_lo) begin
			item.hex_val = lo_off[3:0];
		end else begin
			item.hex_val = up_off[3:0];
		end
	end

endmodule

// ===== src/chbd_queue.sv =====
// ----------------------------------------------------------------------------
// chbd_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module chbd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  chbd_pkg::item_t     push_item,
	output logic                full,
	input  logic                pop,
	output chbd_pkg::q_out_t    head
);

	chbd_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full       = count_q[1];
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

endmodule

// ===== src/chbd_back.sv =====
// ----------------------------------------------------------------------------
// chbd_back
// Chunk framing state machine and registered result stage.
// ----------------------------------------------------------------------------
module chbd_back #(
	parameter int MAX_SIZE_DIGITS = 8,
	parameter int TOTAL_BITS      = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  chbd_pkg::q_out_t    head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          payload,
	output logic [2:0]          error_code,
	output logic [31:0]         body_length
);

	localparam int ACC_W = 4 * MAX_SIZE_DIGITS;
	localparam int DC_W  = $clog2(MAX_SIZE_DIGITS + 1);
	localparam logic [DC_W-1:0] DC_MAX = DC_W'(MAX_SIZE_DIGITS);

	// State registers
	chbd_pkg::phase_t       phase_q;
	logic [ACC_W-1:0]       acc_q;
	logic [DC_W-1:0]        dc_q;
	logic [30:0]            rem_q;
	logic                   final_q;
	logic [TOTAL_BITS-1:0]  total_q;
	chbd_pkg::err_t         err_q;

	// Effective state after an optional restart
	chbd_pkg::phase_t       ph;
	logic [ACC_W-1:0]       acc;
	logic [DC_W-1:0]        dc;
	logic [30:0]            rem;
	logic                   fin;
	logic [TOTAL_BITS-1:0]  tot;
	chbd_pkg::err_t         err;

	// Next state
	chbd_pkg::phase_t       phase_d;
	logic [ACC_W-1:0]       acc_d;
	logic [DC_W-1:0]        dc_d;
	logic [30:0]            rem_d;
	logic                   final_d;
	logic [TOTAL_BITS-1:0]  total_d;
	chbd_pkg::err_t         err_d;
	chbd_pkg::kind_t        kind_d;
	logic [7:0]             pay_d;

	logic [31:0]            acc32;
	logic [63:0]            tot64;
	logic [31:0]            len;
	chbd_pkg::item_t        it;

	assign it  = head.item;
	assign pop = head.valid && (!out_valid || out_ready);

	// Framing decode
	always_comb begin
		ph  = it.first ? chbd_pkg::PH_SIZE : phase_q;
		acc = it.first ? '0 : acc_q;
		dc  = it.first ? '0 : dc_q;
		rem = it.first ? '0 : rem_q;
		fin = it.first ? 1'b0 : final_q;
		tot = it.first ? '0 : total_q;
		err = it.first ? chbd_pkg::ERR_NO_DIGIT : err_q;

		phase_d = ph;
		acc_d   = acc;
		dc_d    = dc;
		rem_d   = rem;
		final_d = fin;
		total_d = tot;
		err_d   = err;
		kind_d  = chbd_pkg::KIND_FRAME;
		pay_d   = 8'd0;
		acc32   = 32'(acc);

		unique case (ph)
			chbd_pkg::PH_SIZE: begin
				priority if (it.is_hex) begin
					if (dc >= DC_MAX) begin
						phase_d = chbd_pkg::PH_ERROR;
						err_d   = chbd_pkg::ERR_MANY_DIGITS;
						kind_d  = chbd_pkg::KIND_ERROR;
					end else begin
						acc_d = ACC_W'({acc, it.hex_val});
						dc_d  = dc + DC_W'(1);
					end
				end else if (dc == '0) begin
					phase_d = chbd_pkg::PH_ERROR;
					err_d   = chbd_pkg::ERR_NO_DIGIT;
					kind_d  = chbd_pkg::KIND_ERROR;
				end else if (it.is_cr) begin
					phase_d = chbd_pkg::PH_SIZE_LF;
				end else begin
					phase_d = chbd_pkg::PH_ERROR;
					err_d   = chbd_pkg::ERR_SIZE_CRLF;
					kind_d  = chbd_pkg::KIND_ERROR;
				end
			end
			chbd_pkg::PH_SIZE_LF: begin
				priority if (!it.is_lf) begin
					phase_d = chbd_pkg::PH_ERROR;
					err_d   = chbd_pkg::ERR_SIZE_CRLF;
					kind_d  = chbd_pkg::KIND_ERROR;
				end else if (acc32[31]) begin
					phase_d = chbd_pkg::PH_ERROR;
					err_d   = chbd_pkg::ERR_SIZE_LARGE;
					kind_d  = chbd_pkg::KIND_ERROR;
				end else if (acc32 == 32'd0) begin
					final_d = 1'b1;
					phase_d = chbd_pkg::PH_DATA_CR;
				end else begin
					rem_d   = acc32[30:0];
					phase_d = chbd_pkg::PH_DATA;
				end
			end
			chbd_pkg::PH_DATA: begin
				kind_d = chbd_pkg::KIND_PAYLOAD;
				pay_d  = it.data;
				if (!(&tot)) total_d = tot + TOTAL_BITS'(1);
				rem_d = rem - 31'd1;
				if (rem == 31'd1) phase_d = chbd_pkg::PH_DATA_CR;
			end
			chbd_pkg::PH_DATA_CR: begin
				if (it.is_cr) begin
					phase_d = chbd_pkg::PH_DATA_LF;
				end else begin
					phase_d = chbd_pkg::PH_ERROR;
					err_d   = chbd_pkg::ERR_DATA_CRLF;
					kind_d  = chbd_pkg::KIND_ERROR;
				end
			end
			chbd_pkg::PH_DATA_LF: begin
				priority if (!it.is_lf) begin
					phase_d = chbd_pkg::PH_ERROR;
					err_d   = chbd_pkg::ERR_DATA_CRLF;
					kind_d  = chbd_pkg::KIND_ERROR;
				end else if (fin) begin
					phase_d = chbd_pkg::PH_DONE;
					kind_d  = chbd_pkg::KIND_DONE;
				end else begin
					phase_d = chbd_pkg::PH_SIZE;
					acc_d   = '0;
					dc_d    = '0;
				end
			end
			chbd_pkg::PH_DONE: begin
				kind_d = chbd_pkg::KIND_DONE;
			end
			default: begin
				phase_d = chbd_pkg::PH_ERROR;
				kind_d  = chbd_pkg::KIND_ERROR;
			end
		endcase

		// Saturated length report
		tot64 = 64'(total_d);
		len   = (|tot64[63:32]) ? 32'hFFFF_FFFF : tot64[31:0];
	end

	// State update on each popped beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= chbd_pkg::PH_SIZE;
			acc_q   <= '0;
			dc_q    <= '0;
			rem_q   <= '0;
			final_q <= 1'b0;
			total_q <= '0;
			err_q   <= chbd_pkg::ERR_NO_DIGIT;
		end else if (pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			dc_q    <= dc_d;
			rem_q   <= rem_d;
			final_q <= final_d;
			total_q <= total_d;
			err_q   <= err_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind        <= kind_d;
			payload     <= pay_d;
			error_code  <= (kind_d == chbd_pkg::KIND_ERROR) ? err_d : 3'd0;
			body_length <= (kind_d == chbd_pkg::KIND_DONE) ? len : 32'd0;
		end
	end

endmodule

// ===== sim/http_chunked_body_decoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit_test
// Self-checking bench for the chunked body decoder. A short table of directed
// beats (clean body, after-completion bytes, each error code, held errors)
// is followed by random bodies, mostly well formed with random sizes and
// payload, some broken or oversized, some pure noise. Every accepted input
// beat runs through a behavioral decoder whose result is queued and compared
// field by field with the result beats, under random idling on both sides.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit_test;

	localparam int SIZE_DIGITS_MAX = 8;
	localparam int TOTAL_BITS      = 32;
	localparam int RANDOM_BEATS    = 1500;
	localparam int HOLD_CYCLES     = 200;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int REPORT_MAX      = 10;

	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;

	typedef struct packed {
		chbd_pkg::kind_t kind;
		logic [7:0]      payload;
		logic [2:0]      err;
		logic [31:0]     len;
	} result_t;

	// one line of the directed table; reps repeats the byte, first only on the first
	typedef struct packed {
		logic [7:0] b;
		logic       f;
		logic [3:0] reps;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  body_byte;
	logic        first;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  payload;
	logic [2:0]  error_code;
	logic [31:0] body_length;

	http_chunked_body_decoder_unit #(
		.MAX_SIZE_DIGITS(SIZE_DIGITS_MAX),
		.TOTAL_BITS(TOTAL_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.body_byte(body_byte),
		.first(first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload(payload),
		.error_code(error_code),
		.body_length(body_length)
	);

	result_t    pending_results [$];
	dir_row_t   dir_rows [$];
	logic [7:0] body_q [$];
	int         miss_cnt = 0;
	int         cycle_cnt = 0;
	int         rand_sent;
	bit         tx_burst;
	bit         hold_off_req;

	// decoder state mirror
	chbd_pkg::phase_t dec_phase;
	logic [31:0]      dec_size;
	int               dec_digits;
	logic [30:0]      dec_left;
	bit               dec_last_chunk;
	logic [31:0]      dec_total;
	chbd_pkg::err_t   dec_err;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void decoder_clear();
		dec_phase      = chbd_pkg::PH_SIZE;
		dec_size       = '0;
		dec_digits     = 0;
		dec_left       = '0;
		dec_last_chunk = 1'b0;
		dec_total      = '0;
		dec_err        = chbd_pkg::ERR_NO_DIGIT;
	endfunction

	function automatic chbd_pkg::kind_t dec_fail(input chbd_pkg::err_t code);
		dec_phase = chbd_pkg::PH_ERROR;
		dec_err   = code;
		return chbd_pkg::KIND_ERROR;
	endfunction

	// result of one body byte, advancing the mirrored decoder state
	function automatic result_t chunk_decode_step(input logic [7:0] b, input logic f);
		result_t    r;
		logic [4:0] nib;
		if (f)
			decoder_clear();
		r = '0;
		r.kind = chbd_pkg::KIND_FRAME;
		// bit 4 marks a hex digit
		if (b >= CH_0 && b <= CH_9)
			nib = {1'b1, 4'(b - CH_0)};
		else if (b >= CH_LO_A && b <= CH_LO_F)
			nib = {1'b1, 4'(b - CH_LO_A + 8'd10)};
		else if (b >= CH_UP_A && b <= CH_UP_F)
			nib = {1'b1, 4'(b - CH_UP_A + 8'd10)};
		else
			nib = '0;
		case (dec_phase)
			chbd_pkg::PH_SIZE: begin
				if (nib[4]) begin
					if (dec_digits >= SIZE_DIGITS_MAX)
						r.kind = dec_fail(chbd_pkg::ERR_MANY_DIGITS);
					else begin
						dec_size = {dec_size[27:0], nib[3:0]};
						dec_digits++;
					end
				end else if (dec_digits == 0)
					r.kind = dec_fail(chbd_pkg::ERR_NO_DIGIT);
				else if (b == chbd_pkg::CHAR_CR)
					dec_phase = chbd_pkg::PH_SIZE_LF;
				else
					r.kind = dec_fail(chbd_pkg::ERR_SIZE_CRLF);
			end
			chbd_pkg::PH_SIZE_LF: begin
				if (b != chbd_pkg::CHAR_LF)
					r.kind = dec_fail(chbd_pkg::ERR_SIZE_CRLF);
				else if (dec_size[31])
					r.kind = dec_fail(chbd_pkg::ERR_SIZE_LARGE);
				else if (dec_size == 0) begin
					dec_last_chunk = 1'b1;
					dec_phase = chbd_pkg::PH_DATA_CR;
				end else begin
					dec_left = dec_size[30:0];
					dec_phase = chbd_pkg::PH_DATA;
				end
			end
			chbd_pkg::PH_DATA: begin
				r.kind = chbd_pkg::KIND_PAYLOAD;
				r.payload = b;
				if (dec_total != '1)
					dec_total++;
				dec_left--;
				if (dec_left == 0)
					dec_phase = chbd_pkg::PH_DATA_CR;
			end
			chbd_pkg::PH_DATA_CR: begin
				if (b == chbd_pkg::CHAR_CR)
					dec_phase = chbd_pkg::PH_DATA_LF;
				else
					r.kind = dec_fail(chbd_pkg::ERR_DATA_CRLF);
			end
			chbd_pkg::PH_DATA_LF: begin
				if (b != chbd_pkg::CHAR_LF)
					r.kind = dec_fail(chbd_pkg::ERR_DATA_CRLF);
				else if (dec_last_chunk) begin
					dec_phase = chbd_pkg::PH_DONE;
					r.kind = chbd_pkg::KIND_DONE;
				end else begin
					dec_phase = chbd_pkg::PH_SIZE;
					dec_size = '0;
					dec_digits = 0;
				end
			end
			chbd_pkg::PH_DONE: r.kind = chbd_pkg::KIND_DONE;
			default: begin
				dec_phase = chbd_pkg::PH_ERROR;
				r.kind = chbd_pkg::KIND_ERROR;
			end
		endcase
		if (r.kind == chbd_pkg::KIND_ERROR)
			r.err = dec_err;
		if (r.kind == chbd_pkg::KIND_DONE)
			r.len = dec_total;
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_gap(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit up);
		if (n < 4'd10)
			return CH_0 + 8'(n);
		return (up ? CH_UP_A : CH_LO_A) + 8'(n) - 8'd10;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic f, input logic [3:0] reps,
			input logic typed, input chbd_pkg::kind_t k, input logic [7:0] pay,
			input chbd_pkg::err_t e, input logic [31:0] len);
		dir_row_t row;
		row.b = b;
		row.f = f;
		row.reps = reps;
		row.typed = typed;
		row.want.kind = k;
		row.want.payload = pay;
		row.want.err = (k == chbd_pkg::KIND_ERROR) ? 3'(e) : 3'd0;
		row.want.len = len;
		dir_rows.push_back(row);
	endtask

	// append ndig hex digits of a size, mixed case
	task automatic put_size(input logic [31:0] sz, input int ndig);
		for (int i = ndig - 1; i >= 0; i--)
			body_q.push_back(hex_char(sz[4*i +: 4], 1'($urandom_range(0, 1))));
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic f, input bit typed,
			input result_t want);
		result_t pred;
		int      gap;
		body_byte <= b;
		first <= f;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pred = chunk_decode_step(b, f);
		pending_results.push_back(typed ? want : pred);
		@(negedge clk);
		gap = idle_gap(tx_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// one random body into body_q
	task automatic build_body();
		int pick;
		int sz;
		int nd;
		body_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			// well-formed chunks, then the last chunk
			repeat ($urandom_range(0, 3)) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					sz = $urandom_range(1, 12);
				else if (pick < 95)
					sz = $urandom_range(13, 64);
				else
					sz = $urandom_range(65, 300);
				nd = 1;
				while ((sz >> (4 * nd)) != 0)
					nd++;
				put_size(32'(sz), $urandom_range(nd, SIZE_DIGITS_MAX));
				body_q.push_back(chbd_pkg::CHAR_CR);
				body_q.push_back(chbd_pkg::CHAR_LF);
				repeat (sz) body_q.push_back(8'($urandom_range(0, 255)));
				body_q.push_back(chbd_pkg::CHAR_CR);
				body_q.push_back(chbd_pkg::CHAR_LF);
			end
			put_size('0, $urandom_range(1, SIZE_DIGITS_MAX));
			body_q.push_back(chbd_pkg::CHAR_CR);
			body_q.push_back(chbd_pkg::CHAR_LF);
			body_q.push_back(chbd_pkg::CHAR_CR);
			body_q.push_back(chbd_pkg::CHAR_LF);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) body_q.push_back(8'($urandom_range(0, 255)));
			// some get one byte hit, some are cut short
			pick = $urandom_range(0, 99);
			if (pick < 12)
				body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
			else if (pick < 20) begin
				nd = $urandom_range(1, body_q.size());
				while (body_q.size() > nd)
					void'(body_q.pop_back());
			end
		end else if (pick < 88) begin
			// size with the top bit set
			put_size({1'b1, 31'($urandom)}, SIZE_DIGITS_MAX);
			body_q.push_back(chbd_pkg::CHAR_CR);
			body_q.push_back(chbd_pkg::CHAR_LF);
			repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 94) begin
			// too many size digits
			repeat ($urandom_range(SIZE_DIGITS_MAX + 1, SIZE_DIGITS_MAX + 2))
				body_q.push_back(hex_char(4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
		end else
			repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int stall;
		int hold_cnt;
		bit rx_burst;
		bit hold_taken;
		stall = 0;
		rx_burst = 1'b0;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(negedge clk);
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					rx_burst = !rx_burst;
				stall = idle_gap(rx_burst);
			end
		end
	end

	// compare each result beat with the oldest pending prediction
	always @(posedge clk) begin : check_beats
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				miss_cnt++;
				if (miss_cnt <= REPORT_MAX)
					$display({"%0t: result beat with nothing pending: ",
						"kind=%0d payload=%02h err=%0d len=%0d"},
						$time, kind, payload, error_code, body_length);
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind || payload !== want.payload ||
						error_code !== want.err || body_length !== want.len) begin
					miss_cnt++;
					if (miss_cnt <= REPORT_MAX) begin
						$display("%0t: mismatch: expected kind=%0d payload=%02h err=%0d len=%0d",
							$time, want.kind, want.payload, want.err, want.len);
						$display("%0t:          got kind=%0d payload=%02h err=%0d len=%0d",
							$time, kind, payload, error_code, body_length);
					end
				end
			end
		end
	end

	initial begin : stimulus
		bit hold_done;
		bit pause_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		body_byte = '0;
		first = 1'b0;
		hold_off_req = 1'b0;
		tx_burst = 1'b0;
		rand_sent = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		decoder_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// clean body: a 3-byte chunk holding FF, CR and 00, zero chunk with 3 digits
		add_row("3", 1'b1, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(8'hFF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_PAYLOAD, 8'hFF, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b0,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(8'h00, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_PAYLOAD, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row("0", 1'b0, 4'd3, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_DONE, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd3);
		// byte after completion repeats the length
		add_row(8'h7E, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_DONE, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd3);
		// no size digit, then held
		add_row(chbd_pkg::CHAR_CR, 1'b1, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row("A", 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		// non-hex byte after a digit
		add_row("f", 1'b1, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row("g", 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_SIZE_CRLF, 32'd0);
		// ninth digit
		add_row("F", 1'b1, 4'd8, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row("a", 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_MANY_DIGITS, 32'd0);
		// size 80000000 flagged on the LF
		add_row("8", 1'b1, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row("0", 1'b0, 4'd7, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_SIZE_LARGE, 32'd0);
		// size CR not followed by LF
		add_row("2", 1'b1, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd2, 1'b0,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		// zero chunk trailer CR then a wrong byte, error held afterwards
		add_row("0", 1'b1, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row(chbd_pkg::CHAR_CR, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_FRAME, 8'h00, chbd_pkg::ERR_NO_DIGIT, 32'd0);
		add_row("Z", 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_DATA_CRLF, 32'd0);
		add_row(chbd_pkg::CHAR_LF, 1'b0, 4'd1, 1'b1,
			chbd_pkg::KIND_ERROR, 8'h00, chbd_pkg::ERR_DATA_CRLF, 32'd0);

		foreach (dir_rows[i])
			for (int k = 0; k < dir_rows[i].reps; k++)
				send_byte(dir_rows[i].b, dir_rows[i].f && k == 0, dir_rows[i].typed,
					dir_rows[i].want);

		// random bodies
		while (rand_sent < RANDOM_BEATS) begin
			if (!hold_done && rand_sent >= 300) begin
				// sink stalls long while bytes keep coming
				hold_off_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && rand_sent >= 900) begin
				// source goes quiet until every result is back
				in_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
				@(negedge clk);
				pause_done = 1'b1;
			end
			tx_burst = ($urandom_range(0, 4) == 0);
			build_body();
			foreach (body_q[i])
				send_byte(body_q[i], i == 0, 1'b0, '0);
			rand_sent += body_q.size();
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (miss_cnt == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
